// ===== design/bts_pkg.sv =====
`timescale 1ns / 1ps
package bts_pkg;

  localparam int COORD_BITS   = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int B_MAG        = 14;
  localparam int B_BITS       = B_MAG + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam logic [1:0] SEL_PHI   = 2'd0;
  localparam logic [1:0] SEL_PSI   = 2'd1;
  localparam logic [1:0] SEL_OMEGA = 2'd2;

  typedef struct packed {
    logic       load;
    logic       commit;
    logic       finish;
    logic       wr;
    logic       zero;
    logic       phase_b;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic       pend_valid;
    logic       cur_last;
    logic [2:0] known;
  } sts_t;

  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/bts_dihedral.sv =====
`timescale 1ns / 1ps
module bts_dihedral import bts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  point_t p1,
  input  point_t p2,
  input  point_t p3,
  input  point_t p4,
  output logic   done,
  output angle_t angle
);

  localparam int SHW = $clog2(DIFF_BITS - B_MAG + 1);

  localparam logic [3:0] D_IDLE  = 4'd0;
  localparam logic [3:0] D_SHR   = 4'd1;
  localparam logic [3:0] D_MUL   = 4'd2;
  localparam logic [3:0] D_SQRT  = 4'd3;
  localparam logic [3:0] D_YMUL  = 4'd4;
  localparam logic [3:0] D_YWAIT = 4'd5;
  localparam logic [3:0] D_NLOAD = 4'd6;
  localparam logic [3:0] D_NORM  = 4'd7;
  localparam logic [3:0] D_ROT   = 4'd8;
  localparam logic [3:0] D_CORD  = 4'd9;
  localparam logic [3:0] D_FIN   = 4'd10;

  localparam logic [4:0] MS_LAST1 = 5'd20;
  localparam logic [4:0] MS_Y0    = 5'd21;
  localparam logic [4:0] MS_LAST2 = 5'd22;

  logic [3:0] state;
  logic signed [DIFF_BITS-1:0] braw [9];
  logic signed [DIFF_BITS-1:0] dif [9];
  logic signed [B_BITS-1:0] b [9];
  logic signed [B_BITS-1:0] bs [9];
  logic [DIFF_BITS-1:0] dmag [9];
  logic [DIFF_BITS-1:0] m_or;
  logic [SHW-1:0] sh;
  logic [4:0] ms;
  logic [4:0] tag;
  logic tag_v;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod;
  logic signed [31:0] nv [6];
  logic [31:0] ss, sv, rv, bitv, sq_t;
  logic signed [63:0] xv, yv;
  logic signed [47:0] dv;
  logic [62:0] mx, my;
  logic sgx, sgy, zflag, neg;
  logic signed [33:0] cx, cy, xs, ys;
  logic [31:0] acc, rnd;
  logic [4:0] cnt;

  always_comb begin
    dif[0] = DIFF_BITS'(p2.x) - DIFF_BITS'(p1.x);
    dif[1] = DIFF_BITS'(p2.y) - DIFF_BITS'(p1.y);
    dif[2] = DIFF_BITS'(p2.z) - DIFF_BITS'(p1.z);
    dif[3] = DIFF_BITS'(p3.x) - DIFF_BITS'(p2.x);
    dif[4] = DIFF_BITS'(p3.y) - DIFF_BITS'(p2.y);
    dif[5] = DIFF_BITS'(p3.z) - DIFF_BITS'(p2.z);
    dif[6] = DIFF_BITS'(p4.x) - DIFF_BITS'(p3.x);
    dif[7] = DIFF_BITS'(p4.y) - DIFF_BITS'(p3.y);
    dif[8] = DIFF_BITS'(p4.z) - DIFF_BITS'(p3.z);
  end

  always_comb begin
    m_or = '0;
    for (int i = 0; i < 9; i++) begin
      dmag[i] = braw[i][DIFF_BITS-1] ? DIFF_BITS'(-braw[i]) : DIFF_BITS'(braw[i]);
      m_or = m_or | dmag[i];
    end
    sh = '0;
    for (int i = B_MAG; i < DIFF_BITS; i++) begin
      if (m_or[i]) sh = SHW'(i - B_MAG + 1);
    end
    for (int i = 0; i < 9; i++) begin
      bs[i] = braw[i][DIFF_BITS-1] ? -B_BITS'(dmag[i] >> sh) : B_BITS'(dmag[i] >> sh);
    end
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (ms)
      5'd0:  begin opa = 32'(b[1]); opb = 32'(b[5]); end
      5'd1:  begin opa = 32'(b[2]); opb = 32'(b[4]); end
      5'd2:  begin opa = 32'(b[2]); opb = 32'(b[3]); end
      5'd3:  begin opa = 32'(b[0]); opb = 32'(b[5]); end
      5'd4:  begin opa = 32'(b[0]); opb = 32'(b[4]); end
      5'd5:  begin opa = 32'(b[1]); opb = 32'(b[3]); end
      5'd6:  begin opa = 32'(b[4]); opb = 32'(b[8]); end
      5'd7:  begin opa = 32'(b[5]); opb = 32'(b[7]); end
      5'd8:  begin opa = 32'(b[5]); opb = 32'(b[6]); end
      5'd9:  begin opa = 32'(b[3]); opb = 32'(b[8]); end
      5'd10: begin opa = 32'(b[3]); opb = 32'(b[7]); end
      5'd11: begin opa = 32'(b[4]); opb = 32'(b[6]); end
      5'd12: begin opa = 32'(b[3]); opb = 32'(b[3]); end
      5'd13: begin opa = 32'(b[4]); opb = 32'(b[4]); end
      5'd14: begin opa = 32'(b[5]); opb = 32'(b[5]); end
      5'd15: begin opa = nv[0]; opb = nv[3]; end
      5'd16: begin opa = nv[1]; opb = nv[4]; end
      5'd17: begin opa = nv[2]; opb = nv[5]; end
      5'd18: begin opa = 32'(b[0]); opb = nv[3]; end
      5'd19: begin opa = 32'(b[1]); opb = nv[4]; end
      5'd20: begin opa = 32'(b[2]); opb = nv[5]; end
      5'd21: begin opa = $signed(rv); opb = $signed({8'd0, dv[23:0]}); end
      5'd22: begin opa = $signed(rv); opb = 32'($signed(dv[47:24])); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign sq_t = rv + bitv;
  assign xs   = cx >>> cnt;
  assign ys   = cy >>> cnt;
  assign neg  = sgx && (mx != '0);
  assign rnd  = acc + (32'd1 << (31 - ANGLE_BITS));
  assign done = (state == D_FIN);
  assign angle = zflag ? '0 : angle_t'(rnd[31:32-ANGLE_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      tag_v <= 1'b0;
    end else begin
      tag_v <= 1'b0;
      case (state)
        D_IDLE: if (start) state <= D_SHR;
        D_SHR: state <= D_MUL;
        D_MUL: begin
          tag_v <= 1'b1;
          if (ms == MS_LAST1) state <= D_SQRT;
        end
        D_SQRT: if (bitv == 32'd1) state <= D_YMUL;
        D_YMUL: begin
          tag_v <= 1'b1;
          if (ms == MS_LAST2) state <= D_YWAIT;
        end
        D_YWAIT: state <= D_NLOAD;
        D_NLOAD: state <= D_NORM;
        D_NORM: if ((mx >> 30) == '0 && (my >> 30) == '0) state <= D_ROT;
        D_ROT: state <= D_CORD;
        D_CORD: if (cnt == 5'(CORDIC_STEPS - 1)) state <= D_FIN;
        D_FIN: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    tag  <= ms;
    if (tag_v) begin
      case (tag) inside
        [5'd0:5'd11]: begin
          if (!tag[0]) nv[tag[3:1]] <= $signed(prod[31:0]);
          else nv[tag[3:1]] <= nv[tag[3:1]] - $signed(prod[31:0]);
        end
        5'd12: ss <= prod[31:0];
        [5'd13:5'd14]: ss <= ss + prod[31:0];
        5'd15: xv <= prod;
        [5'd16:5'd17]: xv <= xv + prod;
        5'd18: dv <= prod[47:0];
        [5'd19:5'd20]: dv <= dv + prod[47:0];
        5'd21: yv <= prod;
        5'd22: yv <= yv + (prod <<< 24);
        default: ;
      endcase
    end
    case (state)
      D_IDLE: begin
        for (int i = 0; i < 9; i++) braw[i] <= dif[i];
        ms <= '0;
      end
      D_SHR: for (int i = 0; i < 9; i++) b[i] <= bs[i];
      D_MUL: begin
        ms <= ms + 5'd1;
        if (ms == MS_LAST1) begin
          sv   <= ss;
          rv   <= '0;
          bitv <= 32'd1 << 30;
          ms   <= MS_Y0;
        end
      end
      D_SQRT: begin
        if (sv >= sq_t) begin
          sv <= sv - sq_t;
          rv <= (rv >> 1) + bitv;
        end else begin
          rv <= rv >> 1;
        end
        bitv <= bitv >> 2;
      end
      D_YMUL: ms <= ms + 5'd1;
      D_NLOAD: begin
        mx  <= xv[63] ? 63'(-xv) : 63'(xv);
        my  <= yv[63] ? 63'(-yv) : 63'(yv);
        sgx <= xv[63];
        sgy <= yv[63];
      end
      D_NORM: begin
        if ((mx >> 30) != '0 || (my >> 30) != '0) begin
          mx <= mx >> 1;
          my <= my >> 1;
        end
      end
      D_ROT: begin
        zflag <= (mx == '0) && (my == '0);
        cx    <= 34'(mx);
        cy    <= (sgy ^ neg) ? -34'(my) : 34'(my);
        acc   <= neg ? 32'h8000_0000 : 32'h0;
        cnt   <= '0;
      end
      D_CORD: begin
        if (!cy[33]) begin
          cx  <= cx + ys;
          cy  <= cy - xs;
          acc <= acc + atan_step(cnt);
        end else begin
          cx  <= cx - ys;
          cy  <= cy + xs;
          acc <= acc - atan_step(cnt);
        end
        cnt <= cnt + 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/bts_dpath.sv =====
`timescale 1ns / 1ps
module bts_dpath import bts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  coord_t     n_x,
  input  coord_t     n_y,
  input  coord_t     n_z,
  input  coord_t     ca_x,
  input  coord_t     ca_y,
  input  coord_t     ca_z,
  input  coord_t     c_x,
  input  coord_t     c_y,
  input  coord_t     c_z,
  input  logic [2:0] atoms_present,
  input  logic       break_after,
  input  logic       last_residue,
  input  angle_t     eng_angle,
  output point_t     p1,
  output point_t     p2,
  output point_t     p3,
  output point_t     p4,
  output angle_t     phi,
  output angle_t     psi,
  output angle_t     omega,
  output logic [2:0] angles_known,
  output logic       chain_end
);

  point_t cn, cca, cc, pn, pca, pc, ec;
  logic [2:0] cur_mask;
  logic cur_brk, cur_last;
  logic [3:0] pflags;
  logic pend_valid, ec_ok, gap;
  logic [1:0] nm;
  logic [2:0] known;
  angle_t wval;
  logic wknown;

  assign nm = cmd.phase_b ? 2'b00 : cur_mask[1:0];
  assign known[0] = ec_ok && (pflags[2:0] == 3'b111) && !gap;
  assign known[1] = (pflags[2:0] == 3'b111) && nm[0] && !pflags[3];
  assign known[2] = (pflags[2:1] == 2'b11) && (nm == 2'b11) && !pflags[3];
  assign sts = '{pend_valid: pend_valid, cur_last: cur_last, known: known};

  always_comb begin
    case (cmd.sel)
      SEL_PHI:   begin p1 = ec;  p2 = pn;  p3 = pca; p4 = pc;  end
      SEL_PSI:   begin p1 = pn;  p2 = pca; p3 = pc;  p4 = cn;  end
      SEL_OMEGA: begin p1 = pca; p2 = pc;  p3 = cn;  p4 = cca; end
      default:   begin p1 = ec;  p2 = pn;  p3 = pca; p4 = pc;  end
    endcase
  end

  assign wval   = cmd.zero ? '0 : eng_angle;
  assign wknown = !cmd.zero && known[cmd.sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      pflags     <= '0;
      pend_valid <= 1'b0;
      ec_ok      <= 1'b0;
      gap        <= 1'b1;
    end else begin
      if (cmd.commit) begin
        if (pend_valid) begin
          ec_ok <= pflags[2];
          gap   <= pflags[3];
        end
        pflags     <= {cur_brk, cur_mask};
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
        ec_ok      <= 1'b0;
        gap        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cn       <= '{x: n_x, y: n_y, z: n_z};
      cca      <= '{x: ca_x, y: ca_y, z: ca_z};
      cc       <= '{x: c_x, y: c_y, z: c_z};
      cur_mask <= atoms_present;
      cur_brk  <= break_after;
      cur_last <= last_residue;
    end
    if (cmd.commit) begin
      if (pend_valid) ec <= pc;
      pn  <= cn;
      pca <= cca;
      pc  <= cc;
    end
    if (cmd.wr) begin
      case (cmd.sel)
        SEL_PHI:   phi   <= wval;
        SEL_PSI:   psi   <= wval;
        SEL_OMEGA: omega <= wval;
        default: ;
      endcase
      angles_known[cmd.sel] <= wknown;
      chain_end <= cmd.phase_b;
    end
  end

endmodule

// ===== design/bts_ctrl.sv =====
`timescale 1ns / 1ps
module bts_ctrl import bts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic eng_done,
  output logic eng_start,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] C_IDLE   = 3'd0;
  localparam logic [2:0] C_ANGLE  = 3'd1;
  localparam logic [2:0] C_WAIT   = 3'd2;
  localparam logic [2:0] C_OUT    = 3'd3;
  localparam logic [2:0] C_COMMIT = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] k, k_next;
  logic phase, phase_next;

  assign in_ready  = (state == C_IDLE);
  assign out_valid = (state == C_OUT);

  always_comb begin
    state_next = state;
    k_next     = k;
    phase_next = phase;
    eng_start  = 1'b0;
    cmd        = '0;
    cmd.sel     = k;
    cmd.phase_b = phase;
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          k_next   = SEL_PHI;
          phase_next = 1'b0;
          state_next = sts.pend_valid ? C_ANGLE : C_COMMIT;
        end
      end
      C_ANGLE: begin
        if (sts.known[k]) begin
          eng_start  = 1'b1;
          state_next = C_WAIT;
        end else begin
          cmd.wr   = 1'b1;
          cmd.zero = 1'b1;
          if (k == SEL_OMEGA) state_next = C_OUT;
          else k_next = k + 2'd1;
        end
      end
      C_WAIT: begin
        if (eng_done) begin
          cmd.wr = 1'b1;
          if (k == SEL_OMEGA) begin
            state_next = C_OUT;
          end else begin
            k_next     = k + 2'd1;
            state_next = C_ANGLE;
          end
        end
      end
      C_OUT: begin
        if (out_ready) begin
          if (phase) begin
            cmd.finish = 1'b1;
            state_next = C_IDLE;
          end else begin
            state_next = C_COMMIT;
          end
        end
      end
      C_COMMIT: begin
        cmd.commit = 1'b1;
        if (sts.cur_last) begin
          phase_next = 1'b1;
          k_next     = SEL_PHI;
          state_next = C_ANGLE;
        end else begin
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      k     <= SEL_PHI;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== design/backbone_torsion_stream.sv =====
`timescale 1ns / 1ps
// channel  | handshake             | beat
// input    | in_valid / in_ready   | n_*, ca_*, c_*, atoms_present, break_after, last_residue
// output   | out_valid / out_ready | phi, psi, omega, angles_known, chain_end
//
// One residue beat is taken at a time; in_ready is high only while idle.
// Each known dihedral runs through the shared engine: 23 products through one
// 32x32 multiplier, a 16-step square root, normalize shifts and 28 CORDIC steps.
// A beat costs up to three dihedrals per result, two results at the chain end.
// Unknown angles skip the engine and are written as zero. Reset (rst) is
// synchronous and starts a new chain. A stalled output beat holds until out_ready.
module backbone_torsion_stream import bts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  coord_t     n_x,
  input  coord_t     n_y,
  input  coord_t     n_z,
  input  coord_t     ca_x,
  input  coord_t     ca_y,
  input  coord_t     ca_z,
  input  coord_t     c_x,
  input  coord_t     c_y,
  input  coord_t     c_z,
  input  logic [2:0] atoms_present,
  input  logic       break_after,
  input  logic       last_residue,
  output logic       out_valid,
  input  logic       out_ready,
  output angle_t     phi,
  output angle_t     psi,
  output angle_t     omega,
  output logic [2:0] angles_known,
  output logic       chain_end
);

  cmd_t cmd;
  sts_t sts;
  logic eng_start, eng_done;
  angle_t eng_angle;
  point_t p1, p2, p3, p4;

  bts_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .eng_done, .eng_start, .cmd, .sts
  );

  bts_dpath u_dpath (
    .clk, .rst, .cmd, .sts,
    .n_x, .n_y, .n_z, .ca_x, .ca_y, .ca_z, .c_x, .c_y, .c_z,
    .atoms_present, .break_after, .last_residue,
    .eng_angle, .p1, .p2, .p3, .p4,
    .phi, .psi, .omega, .angles_known, .chain_end
  );

  bts_dihedral u_dihedral (
    .clk, .rst, .start(eng_start), .p1, .p2, .p3, .p4,
    .done(eng_done), .angle(eng_angle)
  );

endmodule

// ===== design/bts_checker.sv =====
`timescale 1ns / 1ps
module bts_checker import bts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input angle_t     phi,
  input angle_t     psi,
  input angle_t     omega,
  input logic [2:0] angles_known,
  input logic       chain_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phi) && $stable(psi) && $stable(omega))
    else $error("output beat dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before work done");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while a result waits");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && chain_end |-> angles_known[2:1] == 2'b00)
    else $error("chain end result claims psi or omega");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !angles_known[0] |-> phi == '0)
    else $error("unknown phi not zero");

endmodule

bind backbone_torsion_stream bts_checker u_chk (.*);
